/* rtl/prld_pkg.sv */
// prld_pkg: shared types and constants for the PackBits run-length decoder.
// No dependencies; imported by prld_decode and packbits_rle_decoder.
package prld_pkg;

  localparam int ByteW  = 8;
  localparam int TdataW = 16;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_t;

  // One decode step's result toward the output register.
  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] out_byte;
    logic [ByteW-1:0] run_length;
  } dec_result_t;

endpackage

/* rtl/prld_decode.sv */
// prld_decode: phase / count state of the decoder and the per-byte decision.
// Depends on prld_pkg.
module prld_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,     // consume in_byte this cycle
  input  logic [prld_pkg::ByteW-1:0] in_byte,
  output prld_pkg::dec_result_t      result
);
  import prld_pkg::*;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] remaining, remaining_next;
  logic [ByteW-1:0] rem_dec;

  assign rem_dec = (remaining != '0) ? remaining - 8'd1 : '0;

  always_comb begin
    phase_next        = phase;
    remaining_next    = remaining;
    result.emit       = 1'b0;
    result.out_byte   = in_byte;
    result.run_length = 8'd1;
    case (phase)
      PH_LITERAL: begin
        result.emit    = 1'b1;
        remaining_next = rem_dec;
        if (rem_dec == '0) phase_next = PH_HEADER;
      end
      PH_REPEAT: begin
        result.emit       = 1'b1;
        result.run_length = remaining;
        remaining_next    = '0;
        phase_next        = PH_HEADER;
      end
      default: begin
        // header: sign bit picks literal block or repeat run
        if (!in_byte[ByteW-1]) begin
          remaining_next = in_byte + 8'd1;
          phase_next     = PH_LITERAL;
        end else begin
          remaining_next = 8'd1 - in_byte;   // 257 - b, modulo 256
          phase_next     = PH_REPEAT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      remaining <= '0;
    end else if (step) begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end

endmodule

/* rtl/packbits_rle_decoder.sv */
// packbits_rle_decoder: top level, input register, decode step, output register.
// Depends on prld_pkg and prld_decode.
//
// Usage:
//   Slave side (s_tvalid/s_tready/s_tdata) takes one compressed byte per beat.
//   Master side (m_tvalid/m_tready/m_tdata) gives one decoded run per beat:
//   m_tdata[7:0] is the byte value, m_tdata[15:8] the copy count (1..129,
//   1 for every literal). Header bytes are consumed and give no beat.
//   A data byte reaches the master side through two register stages: the
//   input register and the result register. Throughput: one byte per cycle
//   while the master side is not stalled, set by the combinational decode step
//   between the two registers; a header uses an input slot but gives no beat.
//   Reset (rst, synchronous, active high) returns the decoder to the header
//   phase and empties both register stages.
//   When the receiver stalls, the pending result holds steady; the input
//   register still takes one more byte and headers keep draining, so
//   s_tready drops only while a data byte waits behind a stalled result.
module packbits_rle_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [prld_pkg::ByteW-1:0]  s_tdata,   // [7:0] in_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [prld_pkg::TdataW-1:0] m_tdata    // [7:0] out_byte, [15:8] run_length
);
  import prld_pkg::*;

  // input register
  logic             in_valid;
  logic [ByteW-1:0] in_byte;

  dec_result_t result;
  logic        out_free;
  logic        advance;

  assign out_free = !m_tvalid || m_tready;
  // a header never needs the output register, so it always advances
  assign advance  = in_valid && (!result.emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  prld_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (in_byte),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && result.emit) begin
      m_tdata <= {result.run_length, result.out_byte};
    end
  end

endmodule

/* rtl/prld_checker.sv */
// prld_checker: port-level checks for packbits_rle_decoder, bound to the top.
// Depends on the top level's port list only.
module prld_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // run length within 1..129
  a_run_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:8] != 8'd0) && (m_tdata[15:8] <= 8'd129))
    else $error("run length out of range");

  // input backpressure only comes from a stalled output
  a_bp_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("s_tready low without output stall");

endmodule

bind packbits_rle_decoder prld_checker u_prld_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
